FILE: rtl/core/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// Types, character codes and pattern helpers for the color escape stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package ces_pkg;

    localparam int ByteW    = 8;
    localparam int LimitW   = 16;
    localparam int MaxOut   = 4;
    localparam int OutCntW  = 3;
    localparam int ProgW    = 2;

    localparam logic [LimitW-1:0] LIMIT_RESET = 16'd255;

    localparam logic [ByteW-1:0] CHAR_NUL  = 8'h00;
    localparam logic [ByteW-1:0] CHAR_ESC  = 8'h1B;
    localparam logic [ByteW-1:0] CHAR_LBR  = 8'h5B;
    localparam logic [ByteW-1:0] CHAR_SEMI = 8'h3B;
    localparam logic [ByteW-1:0] CHAR_C    = 8'h43;
    localparam logic [ByteW-1:0] CHAR_ZERO = 8'h30;
    localparam logic [ByteW-1:0] CHAR_M    = 8'h6D;

    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_SEGMENT = 2'd2
    } mode_t;

    // Expected byte at a given match position of the prefix or suffix.
    function automatic logic [ByteW-1:0] pattern_byte(input logic seg,
                                                      input logic [ProgW-1:0] idx);
        logic [ByteW-1:0] b;
        unique case (idx)
            2'd0:    b = CHAR_ESC;
            2'd1:    b = CHAR_LBR;
            2'd2:    b = seg ? CHAR_ZERO : CHAR_C;
            default: b = CHAR_M;
        endcase
        return b;
    endfunction

    // Byte held at a given position of a partial match.
    function automatic logic [ByteW-1:0] held_byte(input logic [ProgW-1:0] idx);
        logic [ByteW-1:0] b;
        unique case (idx)
            2'd0:    b = CHAR_ESC;
            2'd1:    b = CHAR_LBR;
            default: b = CHAR_ZERO;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/color_escape_stripper_unit.sv
// ----------------------------------------------------------------------------
// color_escape_stripper_unit
// Strips color escape headers and trailers from a zero-terminated text stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one input byte per transaction; byte 0 ends a string.
//   m_axis_* carries result bytes; tlast marks the last result of one input
//   byte. An input byte yields zero to four results.
//   cfg_we / cfg_wdata load the output limit (text bytes per string); write
//   it only while the block is idle.
// Flow: a byte is registered at acceptance, then processed into a four-entry
//   result buffer once that buffer is empty or handing over its last result,
//   and its results are presented from there.
// Throughput: one input byte per cycle while each byte yields at most one
//   result and m_axis_tready stays high; a byte that flushes a held partial
//   match yields several results, and the next byte is not processed until they drain.
// Reset: clears parse mode, match progress, text count and both buffers, and
//   sets the output limit to 255.
// Stall: when m_axis_tready is low the result buffer holds, the input register
//   fills, and s_axis_tready drops until the buffer drains.
// ----------------------------------------------------------------------------
`default_nettype none

module color_escape_stripper_unit
    import ces_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [LimitW-1:0] cfg_wdata,     // output_limit
    input  wire logic              s_axis_tvalid,
    output      logic              s_axis_tready,
    input  wire logic [ByteW-1:0]  s_axis_tdata,  // [7:0] in_byte
    output      logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output      logic [ByteW-1:0]  m_axis_tdata,  // [7:0] out_byte
    output      logic              m_axis_tlast   // last
);

    logic [LimitW-1:0]  limit_reg;
    mode_t              mode_reg, mode_next;
    logic [ProgW-1:0]   prog_reg, prog_next;
    logic [LimitW-1:0]  count_reg, count_next;
    logic               in_valid_reg;
    logic [ByteW-1:0]   in_byte_reg;
    logic [ByteW-1:0]   buf_reg [MaxOut];
    logic [ByteW-1:0]   buf_next [MaxOut];
    logic [OutCntW-1:0] rem_reg, rem_next;

    logic               take;
    logic               process;
    logic [ByteW-1:0]   x;
    logic               seg;
    logic               match;
    logic [ByteW-1:0]   text_byte [MaxOut];
    logic [OutCntW-1:0] n_text;
    logic               term;
    logic [LimitW:0]    diff;
    logic [OutCntW-1:0] room;
    logic [OutCntW-1:0] n_emit;

    assign take          = m_axis_tvalid && m_axis_tready;
    assign process       = in_valid_reg &&
                           ((rem_reg == '0) || ((rem_reg == OutCntW'(1)) && take));
    assign s_axis_tready = !in_valid_reg || process;
    assign m_axis_tvalid = (rem_reg != '0);
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tlast  = (rem_reg == OutCntW'(1));

    assign x   = in_byte_reg;
    assign seg = (mode_reg == MODE_SEGMENT);

    always_comb
    begin
        mode_next  = mode_reg;
        prog_next  = prog_reg;
        n_text     = '0;
        term       = 1'b0;
        match      = (x != CHAR_NUL) && (x == pattern_byte(seg, prog_reg));
        for (int i = 0; i < MaxOut; i++)
        begin
            text_byte[i] = (OutCntW'(i) < {1'b0, prog_reg}) ? held_byte(ProgW'(i)) : x;
        end

        if (mode_reg == MODE_HEADER)
        begin
            if (x == CHAR_NUL)
                term = 1'b1;
            else if (x == CHAR_SEMI)
                mode_next = MODE_SEGMENT;
        end
        else if (match)
        begin
            if ((seg && prog_reg == 2'd3) || (!seg && prog_reg == 2'd2))
            begin
                mode_next = seg ? MODE_TEXT : MODE_HEADER;
                prog_next = '0;
            end
            else
            begin
                prog_next = prog_reg + 2'd1;
            end
        end
        else
        begin
            n_text    = {1'b0, prog_reg};
            prog_next = '0;
            if (x == CHAR_NUL)
                term = 1'b1;
            else if (x == CHAR_ESC)
                prog_next = 2'd1;
            else
                n_text = {1'b0, prog_reg} + OutCntW'(1);
        end

        // Limit on text bytes per string.
        diff = {1'b0, limit_reg} - {1'b0, count_reg};
        if (limit_reg <= count_reg)
            room = '0;
        else if (diff >= (LimitW+1)'(MaxOut))
            room = OutCntW'(MaxOut);
        else
            room = diff[OutCntW-1:0];
        n_emit     = (n_text < room) ? n_text : room;
        count_next = count_reg + LimitW'(n_emit);

        if (term)
        begin
            mode_next  = MODE_TEXT;
            prog_next  = '0;
            count_next = '0;
        end

        for (int i = 0; i < MaxOut; i++)
        begin
            buf_next[i] = (OutCntW'(i) < n_emit) ? text_byte[i] : CHAR_NUL;
        end
        rem_next = n_emit + OutCntW'(term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            mode_reg     <= MODE_TEXT;
            prog_reg     <= '0;
            count_reg    <= '0;
            in_valid_reg <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
            begin
                mode_reg  <= mode_next;
                prog_reg  <= prog_next;
                count_reg <= count_next;
                rem_reg   <= rem_next;
            end
            else if (take)
            begin
                rem_reg <= rem_reg - OutCntW'(1);
            end
        end
    end

    // Payload: hold the input byte and advance the result buffer.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;

        if (process)
        begin
            for (int i = 0; i < MaxOut; i++)
                buf_reg[i] <= buf_next[i];
        end
        else if (take)
        begin
            for (int i = 0; i < MaxOut - 1; i++)
                buf_reg[i] <= buf_reg[i+1];
            buf_reg[MaxOut-1] <= CHAR_NUL;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ces_checker.sv
// ----------------------------------------------------------------------------
// ces_checker
// Port-level checks for the color escape stripper.
// ----------------------------------------------------------------------------
`default_nettype none

module ces_checker
    import ces_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_we,
    input wire logic [LimitW-1:0] cfg_wdata,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic [ByteW-1:0]  s_axis_tdata,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [ByteW-1:0]  m_axis_tdata,
    input wire logic              m_axis_tlast
);

    logic unused_ok;
    assign unused_ok = cfg_we ^ (|cfg_wdata) ^ s_axis_tvalid ^ (|s_axis_tdata);

    // Stalled transaction stays valid.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Stalled transaction holds its data.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A terminator always closes the results of its input byte.
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata == CHAR_NUL) |-> m_axis_tlast)
        else $error("terminator without tlast");

    // With no result pending, the block must take input.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result buffer");

endmodule

bind color_escape_stripper_unit ces_checker u_ces_checker (.*);

`default_nettype wire
